// File: src/cba_pkg.sv
// Shared constants, codes and controller/datapath interface types for the block allocator.
package cba_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

  localparam int BB_W       = 17;
  localparam int BIU_W      = 9;
  localparam int BYTES_W    = 32;
  localparam int DIVD_W     = BYTES_W + 1;

  localparam logic [BB_W-1:0]  BB_RESET  = BB_W'(512);
  localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(256);

  typedef enum logic [0:0] {
    CFG_BLOCK_BYTES   = 1'b0,
    CFG_BLOCKS_IN_USE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_DEL   = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DUP_ID   = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_NOT_FND  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_SCAN,
    S_ALLOC,
    S_COMPACT,
    S_TAIL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic div_go;
    logic pass_go;
    logic pass_run;
    logic compact;
    logic alloc_go;
    logic alloc_run;
    logic tail_clr;
    logic resp;
  } cmd_t;

  typedef struct packed {
    logic is_add;
    logic is_del;
    logic div_busy;
    logic pass_done;
    logic alloc_done;
    logic tail_done;
    logic any_match;
    logic found;
  } sts_t;

endpackage

// File: src/cba_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module cba_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  logic [cba_pkg::DIVD_W-1:0] dividend_i,
  input  logic [cba_pkg::BB_W-1:0]   divisor_i,
  output logic                       busy_o,
  output logic [cba_pkg::DIVD_W-1:0] quo_o
);
  import cba_pkg::*;

  localparam int CW = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] dq_q, dq_d;
  logic [BB_W-1:0]   rem_q, rem_d;
  logic [BB_W-1:0]   dvs_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [BB_W:0]     rem_sh, rem_sub;
  logic              take;

  always_comb begin
    rem_sh  = {rem_q, dq_q[DIVD_W-1]};
    take    = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
    dq_d    = dq_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (go_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(DIVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = take ? rem_sub[BB_W-1:0] : rem_sh[BB_W-1:0];
      dq_d   = {dq_q[DIVD_W-2:0], take};
      cnt_d  = cnt_q - CW'(1);
      busy_d = cnt_q != CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    if (go_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = dq_q;

endmodule

// File: src/cba_ctrl.sv
// Sequencer for the allocator: divide (add only), scan, allocate or compact and clear the tail, respond.
module cba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cba_pkg::sts_t sts_i,
  output cba_pkg::cmd_t cmd_o
);
  import cba_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (start) state_d = S_PREP;
      S_PREP:    state_d = sts_i.is_add ? S_DIV : S_SCAN;
      S_DIV:     if (!sts_i.div_busy) state_d = S_SCAN;
      S_SCAN: begin
        if (sts_i.pass_done) begin
          if (sts_i.is_add && !sts_i.any_match && sts_i.found) begin
            state_d = S_ALLOC;
          end else if (sts_i.is_del && sts_i.any_match) begin
            state_d = S_COMPACT;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_ALLOC:   if (sts_i.alloc_done) state_d = S_DONE;
      S_COMPACT: if (sts_i.pass_done) state_d = S_TAIL;
      S_TAIL:    if (sts_i.tail_done) state_d = S_DONE;
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:  cmd_o.load = start;
      S_PREP: begin
        cmd_o.div_go  = sts_i.is_add;
        cmd_o.pass_go = !sts_i.is_add;
      end
      S_DIV:   cmd_o.pass_go = !sts_i.div_busy;
      S_SCAN: begin
        cmd_o.pass_run = 1'b1;
        if (sts_i.pass_done) begin
          cmd_o.alloc_go = sts_i.is_add && !sts_i.any_match && sts_i.found;
          cmd_o.pass_go  = sts_i.is_del && sts_i.any_match;
        end
      end
      S_ALLOC: cmd_o.alloc_run = 1'b1;
      S_COMPACT: begin
        cmd_o.pass_run = 1'b1;
        cmd_o.compact  = 1'b1;
      end
      S_TAIL:  cmd_o.tail_clr = 1'b1;
      S_DONE:  cmd_o.resp = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = state_q != S_IDLE;

endmodule

// File: src/cba_dp.sv
// Allocator datapath: block table, scan pipeline, divider, config and result registers.
module cba_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cba_pkg::cmd_t                 cmd_i,
  output cba_pkg::sts_t                 sts_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [cba_pkg::BB_W-1:0]      cfg_wdata_i,
  input  logic [1:0]                    func_i,
  input  logic [7:0]                    file_id_i,
  input  logic [cba_pkg::BYTES_W-1:0]   file_bytes_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [7:0]                    start_block_o,
  output logic [8:0]                    block_count_o,
  output logic [8:0]                    free_blocks_o,
  output logic [8:0]                    used_blocks_o
);
  import cba_pkg::*;

  // configuration
  logic [BB_W-1:0]  bb_q;
  logic [BIU_W-1:0] biu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bb_q  <= BB_RESET;
      biu_q <= BIU_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_BLOCK_BYTES:   bb_q  <= cfg_wdata_i;
        CFG_BLOCKS_IN_USE: biu_q <= cfg_wdata_i[BIU_W-1:0];
        default:           bb_q  <= bb_q;
      endcase
    end
  end

  // latched command
  logic [1:0]         func_q;
  logic [7:0]         id_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [CNT_W-1:0]   n_q;
  logic [CNT_W-1:0]   n_d;

  assign n_d = (32'(biu_q) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(biu_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      id_q    <= file_id_i;
      bytes_q <= file_bytes_i;
      n_q     <= n_d;
    end
  end

  // blocks needed = ceil(bytes / bb)
  logic [BB_W-1:0]   bb_eff;
  logic [DIVD_W-1:0] dividend;
  logic [DIVD_W-1:0] quo;
  logic              div_busy;
  logic              need_big, need_ok;
  logic [CNT_W-1:0]  need;

  assign bb_eff   = (bb_q == '0) ? BB_W'(1) : bb_q;
  assign dividend = {1'b0, bytes_q} + DIVD_W'(bb_eff) - DIVD_W'(1);

  cba_div u_div (
    .clk_i,
    .rst_ni,
    .go_i       (cmd_i.div_go),
    .dividend_i (dividend),
    .divisor_i  (bb_eff),
    .busy_o     (div_busy),
    .quo_o      (quo)
  );

  assign need_big = quo > DIVD_W'(n_q);
  assign need_ok  = !need_big && (quo != '0);
  assign need     = quo[CNT_W-1:0];

  // table: used bits in flops, owners in a memory
  logic [NUM_BLOCKS-1:0] used_q, used_d;
  logic [7:0]            owner_mem [NUM_BLOCKS];
  logic [7:0]            own_rd_q;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  logic [7:0]            mem_wd;

  // walk pipeline: address stage then evaluate stage
  logic [CNT_W-1:0] rd_q, wr_q, run_q, run_nx, used_cnt_q, match_q, alloc_a_q, alloc_rem_q;
  logic [IDX_W-1:0] pidx_q, start_q;
  logic             pv_q, pused_q, found_q;
  logic             issue, hit, c_wr, a_wr, pass_done, tail_done;
  logic [CNT_W-1:0] start_c;

  assign issue     = cmd_i.pass_run && (rd_q < n_q);
  assign pass_done = (rd_q >= n_q) && !pv_q;
  assign tail_done = wr_q >= n_q;
  assign hit       = pv_q && pused_q && (own_rd_q == id_q);
  assign c_wr      = cmd_i.compact && pv_q && pused_q && (own_rd_q != id_q);
  assign a_wr      = cmd_i.alloc_run && (alloc_rem_q != '0);
  assign run_nx    = pused_q ? '0 : run_q + CNT_W'(1);
  assign start_c   = CNT_W'(pidx_q) + CNT_W'(1) - need;

  always_comb begin
    mem_we = c_wr || a_wr;
    mem_wa = c_wr ? wr_q[IDX_W-1:0] : alloc_a_q[IDX_W-1:0];
    mem_wd = c_wr ? own_rd_q : id_q;
  end

  // used bits: set by allocation and compaction writes; the tail after compaction is freed one block per cycle
  always_comb begin
    used_d = used_q;
    if (a_wr) used_d[alloc_a_q[IDX_W-1:0]] = 1'b1;
    if (c_wr) used_d[wr_q[IDX_W-1:0]] = 1'b1;
    if (cmd_i.tail_clr && !tail_done) used_d[wr_q[IDX_W-1:0]] = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      owner_mem[mem_wa] <= mem_wd;
    end
    own_rd_q <= owner_mem[rd_q[IDX_W-1:0]];
    pused_q  <= used_q[rd_q[IDX_W-1:0]];
    pidx_q   <= rd_q[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      run_q       <= '0;
      pv_q        <= 1'b0;
      found_q     <= 1'b0;
      start_q     <= '0;
      used_cnt_q  <= '0;
      match_q     <= '0;
      alloc_a_q   <= '0;
      alloc_rem_q <= '0;
    end else begin
      used_q <= used_d;
      pv_q   <= issue;
      if (issue) rd_q <= rd_q + CNT_W'(1);
      if (cmd_i.pass_go) begin
        rd_q <= '0;
        wr_q <= '0;
        pv_q <= 1'b0;
        if (!cmd_i.pass_run) begin
          run_q      <= '0;
          found_q    <= 1'b0;
          used_cnt_q <= '0;
          match_q    <= '0;
        end
      end else if (cmd_i.compact) begin
        if (c_wr) wr_q <= wr_q + CNT_W'(1);
      end else if (cmd_i.tail_clr) begin
        if (!tail_done) wr_q <= wr_q + CNT_W'(1);
      end else if (cmd_i.pass_run && pv_q) begin
        if (pused_q) used_cnt_q <= used_cnt_q + CNT_W'(1);
        if (hit) match_q <= match_q + CNT_W'(1);
        run_q <= run_nx;
        if (!found_q && need_ok && !pused_q && run_nx == need) begin
          found_q <= 1'b1;
          start_q <= start_c[IDX_W-1:0];
        end
      end
      if (cmd_i.alloc_go) begin
        alloc_a_q   <= CNT_W'(start_q);
        alloc_rem_q <= need;
      end else if (a_wr) begin
        alloc_a_q   <= alloc_a_q + CNT_W'(1);
        alloc_rem_q <= alloc_rem_q - CNT_W'(1);
      end
    end
  end

  always_comb begin
    sts_o.is_add     = func_e'(func_q) == FUNC_ADD;
    sts_o.is_del     = func_e'(func_q) == FUNC_DEL;
    sts_o.div_busy   = div_busy;
    sts_o.pass_done  = pass_done;
    sts_o.alloc_done = alloc_rem_q == '0;
    sts_o.tail_done  = tail_done;
    sts_o.any_match  = match_q != '0;
    sts_o.found      = found_q;
  end

  // result
  status_e          res_st;
  logic [IDX_W-1:0] res_start;
  logic [CNT_W-1:0] res_cnt, res_used;

  always_comb begin
    res_st    = ST_OK;
    res_start = '0;
    res_cnt   = '0;
    res_used  = used_cnt_q;
    case (func_e'(func_q))
      FUNC_ADD: begin
        if (match_q != '0) begin
          res_st = ST_DUP_ID;
        end else if (quo == '0) begin
          res_st = ST_OK;
        end else if (found_q) begin
          res_start = start_q;
          res_cnt   = need;
          res_used  = used_cnt_q + need;
        end else begin
          res_st = ST_NO_SPACE;
        end
      end
      FUNC_DEL: begin
        if (match_q == '0) begin
          res_st = ST_NOT_FND;
        end else begin
          res_cnt  = match_q;
          res_used = used_cnt_q - match_q;
        end
      end
      default: res_st = ST_OK;
    endcase
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.resp;
    end
  end

  logic [1:0] status_q;
  logic [7:0] start_block_q;
  logic [8:0] block_count_q, free_blocks_q, used_blocks_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      status_q      <= res_st;
      start_block_q <= 8'(res_start);
      block_count_q <= 9'(res_cnt);
      free_blocks_q <= 9'(n_q - res_used);
      used_blocks_q <= 9'(res_used);
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign start_block_o = start_block_q;
  assign block_count_o = block_count_q;
  assign free_blocks_o = free_blocks_q;
  assign used_blocks_o = used_blocks_q;

  a_alloc_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_wr |-> alloc_a_q < n_q)
    else $error("allocation write beyond active blocks");

  a_compact_behind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_wr |-> wr_q <= CNT_W'(pidx_q))
    else $error("compaction write ahead of read");

  a_used_le_n : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.resp |-> res_used <= n_q)
    else $error("used count exceeds active blocks");

  a_tail_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.compact && pass_done) |-> wr_q == used_cnt_q - match_q)
    else $error("compaction left wrong number of blocks");

endmodule

// File: src/contiguous_block_allocator_unit.sv
// Top level of the contiguous block allocator: controller plus datapath.
// One command at a time: start is taken when busy is low, and done_o pulses for one
// cycle with the result; the result cannot be held off, so capture it on that cycle.
// Every command walks the active table at one entry per cycle through the
// single-read owner memory (n = active blocks). Query: the walk only. Add: a
// bit-serial divide for the block count, the walk, then, if the id is new and
// space is found, the allocated blocks written one per cycle. Delete: the walk,
// then, if the id is found, a compaction walk and the entries behind the kept
// blocks cleared one per cycle. Reset clears the table at once; no clearing pass is needed.
module contiguous_block_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_addr_i,
  input  logic [cba_pkg::BB_W-1:0]    cfg_wdata_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  func_i,
  input  logic [7:0]                  file_id_i,
  input  logic [cba_pkg::BYTES_W-1:0] file_bytes_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [7:0]                  start_block_o,
  output logic [8:0]                  block_count_o,
  output logic [8:0]                  free_blocks_o,
  output logic [8:0]                  used_blocks_o
);
  import cba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cba_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  cba_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .sts_o (sts),
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .func_i,
    .file_id_i,
    .file_bytes_i,
    .done_o,
    .status_o,
    .start_block_o,
    .block_count_o,
    .free_blocks_o,
    .used_blocks_o
  );

endmodule
